### design/assert_macros.svh
// Assertion macros shared by the coefficient solver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define TCS_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("tcs assertion failed");
// Checked on every clock edge, reset included.
`define TCS_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("tcs assertion failed");
`else
`define TCS_ASSERT(label, prop)
`define TCS_ASSERT_ALWAYS(label, prop)
`endif
`endif

### design/tcs_pkg.sv
// Shared types, constants and saturation helpers of the coefficient solver.
`default_nettype none
package tcs_pkg;
   typedef logic signed [63:0] word_type;

   localparam int WORK_FRAC        = 48;
   localparam int OUT_FRAC_BITS_DEF = 48;
   localparam int RES_BITS_DEF      = 24;
   localparam int RES_W            = 24;
   localparam int TEMP_W           = 18;
   localparam int RLN_W            = 32;
   localparam int DATA_IN_W        = 128;
   localparam int DATA_OUT_W       = 192;

   localparam word_type KELVIN_Q16 = 64'sd17901158;
   localparam word_type LN2_Q62    = 64'sh2C5C85FDF473DE6B;
   localparam logic [63:0] MAX_MAG = 64'h7FFF_FFFF_FFFF_FFFF;

   // Pipeline depths of the arithmetic units.
   localparam int LAT_MUL  = 4;
   localparam int LAT_LN   = 1 + 2 * WORK_FRAC + LAT_MUL;
   localparam int LAT_DIVW = 67 + WORK_FRAC;
   localparam int LAT_DIVU = 67 + WORK_FRAC + 16;

   function automatic logic [63:0] mag64(input word_type x);
      return x[63] ? (64'd0 - 64'(x)) : 64'(x);
   endfunction

   function automatic word_type make64(input logic neg, input logic [63:0] m);
      logic [63:0] mm;
      mm = (m > MAX_MAG) ? MAX_MAG : m;
      return neg ? word_type'(64'd0 - mm) : word_type'(mm);
   endfunction

   function automatic word_type sat_sub(input word_type a, input word_type b);
      logic signed [64:0] d;
      d = {a[63], a} - {b[63], b};
      if (d[64] != d[63]) begin
         return d[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return d[63:0];
   endfunction
endpackage
`default_nettype wire

### design/thermistor_coefficient_solver_top.sv
// Top level of the three-point thermistor coefficient solver.
//
// Usage: one request word carries three calibration pairs (resistance in
// ohms, temperature in Celsius with 8 fraction bits). One response word
// returns 100*A, 100*B and 100*C with OUT_FRAC_BITS fraction bits and a
// solve_error flag; on error all coefficients are zero.
// Throughput: one word per cycle unless the output stalls. Depth: 495 register
// stages, set by the log unit (48 squarings of the mantissa, two stages each)
// and by four chained restoring dividers that form one quotient bit per stage.
// Reset clears every valid bit in the pipeline; data registers are not
// cleared. When the receiver holds rsp_tready low with a response waiting,
// the whole pipeline freezes and req_tready drops in the same cycle;
// nothing is lost or repeated and the response word stays stable.
// The block keeps no state between words.
`default_nettype none
`include "assert_macros.svh"
module thermistor_coefficient_solver_top #(
   parameter int OUT_FRAC_BITS = tcs_pkg::OUT_FRAC_BITS_DEF,
   parameter int RES_BITS      = tcs_pkg::RES_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // resistance_0, temperature_0, resistance_1, temperature_1,
   // resistance_2, temperature_2, then zero fill
   input  wire logic [tcs_pkg::DATA_IN_W-1:0]    req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // coeff_a, coeff_b, coeff_c
   output logic      [tcs_pkg::DATA_OUT_W-1:0]   rsp_tdata,
   // solve_error
   output logic      [0:0]                       rsp_tuser
);
   typedef tcs_pkg::word_type word_type;

   localparam int LM  = tcs_pkg::LAT_MUL;
   localparam int LDW = tcs_pkg::LAT_DIVW;
   localparam int T_L  = 1 + tcs_pkg::LAT_LN;
   localparam int T_L3 = T_L + 2 * LM;
   localparam int T1   = 1 + tcs_pkg::LAT_DIVU;
   localparam int T2   = T1 + 1;
   localparam int T3   = T2 + LM + LDW + 1;
   localparam int T4   = T3 + LDW;
   localparam int T5   = T4 + LM + LDW + 1;
   localparam int T6   = T5 + LM + 2;
   localparam int LAT  = T6 + 1;

   localparam int SH_OUT = OUT_FRAC_BITS - tcs_pkg::WORK_FRAC;
   localparam int UPS    = (SH_OUT >= 0) ? SH_OUT : 0;
   localparam int DNS    = (SH_OUT < 0) ? -SH_OUT : 0;
   localparam logic [63:0] RND_OUT = (DNS > 0) ? (64'd1 << (DNS - 1)) : 64'd0;
   localparam logic [63:0] UP_LIM  = tcs_pkg::MAX_MAG >> UPS;
   localparam logic [tcs_pkg::RLN_W-1:0] RMASK =
      (RES_BITS >= tcs_pkg::RLN_W) ? '1 : ((32'd1 << RES_BITS) - 32'd1);

   function automatic word_type scale_out(input word_type v);
      logic [63:0] m;
      m = tcs_pkg::mag64(v);
      if (SH_OUT >= 0) begin
         if (m > UP_LIM) begin
            return tcs_pkg::make64(v[63], '1);
         end
         return tcs_pkg::make64(v[63], m << UPS);
      end
      return tcs_pkg::make64(v[63], (m + RND_OUT) >> DNS);
   endfunction

   logic advance;
   logic [LAT-1:0] valid_ff;

   assign advance    = !valid_ff[LAT-1] || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = valid_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[LAT-2:0], req_tvalid};
      end
   end

   // Entry registers.
   logic [tcs_pkg::RES_W-1:0]  res_ff  [0:2];
   logic [tcs_pkg::TEMP_W-1:0] temp_ff [0:2];

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff[0]  <= req_tdata[23:0];
         temp_ff[0] <= req_tdata[41:24];
         res_ff[1]  <= req_tdata[65:42];
         temp_ff[1] <= req_tdata[83:66];
         res_ff[2]  <= req_tdata[107:84];
         temp_ff[2] <= req_tdata[125:108];
      end
   end

   logic [tcs_pkg::RLN_W-1:0] rm [0:2];
   word_type kel [0:2];
   word_type ln_v [0:2], ln_d4 [0:2], sq_v [0:2], cube_v [0:2], u_v [0:2];
   word_type ln_a [0:2], cube_a [0:2];
   logic [2:0] bad_pair;
   logic err0, err1;

   for (genvar i = 0; i < 3; i++) begin : g_pair
      assign rm[i]  = tcs_pkg::RLN_W'(res_ff[i]) & RMASK;
      assign kel[i] = (word_type'(signed'(temp_ff[i])) <<< 8) + tcs_pkg::KELVIN_Q16;
      assign bad_pair[i] = (rm[i] == '0) || (kel[i] <= 0);

      tcs_ln u_ln (
         .clock(clock), .advance(advance), .r(rm[i]), .ln_out(ln_v[i])
      );
      tcs_delay #(.W(64), .N(LM)) u_ln_d (
         .clock(clock), .advance(advance), .din(ln_v[i]), .dout(ln_d4[i])
      );
      tcs_mul u_sq (
         .clock(clock), .advance(advance), .a(ln_v[i]), .b(ln_v[i]), .p(sq_v[i])
      );
      tcs_mul u_cube (
         .clock(clock), .advance(advance), .a(sq_v[i]), .b(ln_d4[i]), .p(cube_v[i])
      );
      tcs_div #(.SH(tcs_pkg::WORK_FRAC + 16)) u_inv (
         .clock(clock), .advance(advance), .n(64'sd100), .d(kel[i]), .q(u_v[i])
      );
      tcs_delay #(.W(64), .N(T1 - T_L)) u_ln_al (
         .clock(clock), .advance(advance), .din(ln_v[i]), .dout(ln_a[i])
      );
      tcs_delay #(.W(64), .N(T1 - T_L3)) u_cube_al (
         .clock(clock), .advance(advance), .din(cube_v[i]), .dout(cube_a[i])
      );
   end

   assign err0 = |bad_pair;
   tcs_delay #(.W(1), .N(T1 - 1)) u_err0_d (
      .clock(clock), .advance(advance), .din(err0), .dout(err1)
   );

   // Differences of the three points.
   word_type dba_ff, dca_ff, du10_ff, dcub_ff, d20_ff, d3ca_ff;
   word_type l0_ff, l30_ff, u0_ff;
   logic err2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         dba_ff  <= tcs_pkg::sat_sub(ln_a[1], ln_a[0]);
         dca_ff  <= tcs_pkg::sat_sub(ln_a[2], ln_a[0]);
         du10_ff <= tcs_pkg::sat_sub(u_v[1], u_v[0]);
         dcub_ff <= tcs_pkg::sat_sub(cube_a[1], cube_a[0]);
         d20_ff  <= tcs_pkg::sat_sub(u_v[2], u_v[0]);
         d3ca_ff <= tcs_pkg::sat_sub(cube_a[2], cube_a[0]);
         l0_ff   <= ln_a[0];
         l30_ff  <= cube_a[0];
         u0_ff   <= u_v[0];
         err2_ff <= err1 || (tcs_pkg::sat_sub(ln_a[1], ln_a[0]) == '0);
      end
   end

   word_type dba_q1, dba_q3, dca_m2, dcub_t, d20_d, d3ca_d;
   word_type m1, q1, q2, m2, bq, bq_d;
   word_type help100_ff, help2_ff;
   logic err2_d, err3, err_out;

   tcs_delay #(.W(64), .N(LM)) u_dba_a (
      .clock(clock), .advance(advance), .din(dba_ff), .dout(dba_q1)
   );
   tcs_delay #(.W(64), .N(T4 + LM - T2)) u_dba_b (
      .clock(clock), .advance(advance), .din(dba_ff), .dout(dba_q3)
   );
   tcs_delay #(.W(64), .N(LDW)) u_dca_d (
      .clock(clock), .advance(advance), .din(dca_ff), .dout(dca_m2)
   );
   tcs_delay #(.W(64), .N(T4 - T2)) u_dcub_d (
      .clock(clock), .advance(advance), .din(dcub_ff), .dout(dcub_t)
   );
   tcs_delay #(.W(64), .N(LM + LDW)) u_d20_d (
      .clock(clock), .advance(advance), .din(d20_ff), .dout(d20_d)
   );
   tcs_delay #(.W(64), .N(LM + LDW)) u_d3ca_d (
      .clock(clock), .advance(advance), .din(d3ca_ff), .dout(d3ca_d)
   );
   tcs_delay #(.W(1), .N(T3 - T2)) u_err2_d (
      .clock(clock), .advance(advance), .din(err2_ff), .dout(err2_d)
   );

   tcs_mul u_m1 (.clock(clock), .advance(advance), .a(du10_ff), .b(dca_ff), .p(m1));
   tcs_div u_q1 (.clock(clock), .advance(advance), .n(m1), .d(dba_q1), .q(q1));
   tcs_div u_q2 (.clock(clock), .advance(advance), .n(dcub_ff), .d(dba_ff), .q(q2));
   tcs_mul u_m2 (.clock(clock), .advance(advance), .a(q2), .b(dca_m2), .p(m2));
   tcs_div u_bq (.clock(clock), .advance(advance), .n(du10_ff), .d(dba_ff), .q(bq));

   always_ff @(posedge clock) begin
      if (advance) begin
         help100_ff <= tcs_pkg::sat_sub(d20_d, q1);
         help2_ff   <= tcs_pkg::sat_sub(d3ca_d, m2);
      end
   end

   assign err3 = err2_d || (help2_ff == '0);

   word_type cc, tm, q3, cc_m4, cc_out, l0_d, l30_d, u0_d, m3, m4, bb_out;
   word_type bb_ff, aa1_ff, m4_ff, aa_ff;

   tcs_div u_cc (.clock(clock), .advance(advance), .n(help100_ff), .d(help2_ff), .q(cc));
   tcs_mul u_tm (.clock(clock), .advance(advance), .a(cc), .b(dcub_t), .p(tm));
   tcs_div u_q3 (.clock(clock), .advance(advance), .n(tm), .d(dba_q3), .q(q3));

   tcs_delay #(.W(64), .N((T5 - 1) - (T2 + LDW))) u_bq_d (
      .clock(clock), .advance(advance), .din(bq), .dout(bq_d)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         bb_ff <= tcs_pkg::sat_sub(bq_d, q3);
      end
   end

   tcs_delay #(.W(64), .N(T5 - T4)) u_cc_d (
      .clock(clock), .advance(advance), .din(cc), .dout(cc_m4)
   );
   tcs_delay #(.W(64), .N(T6 - T5)) u_cc_o (
      .clock(clock), .advance(advance), .din(cc_m4), .dout(cc_out)
   );
   tcs_delay #(.W(64), .N(T5 - T2)) u_l0_d (
      .clock(clock), .advance(advance), .din(l0_ff), .dout(l0_d)
   );
   tcs_delay #(.W(64), .N(T5 - T2)) u_l30_d (
      .clock(clock), .advance(advance), .din(l30_ff), .dout(l30_d)
   );
   tcs_delay #(.W(64), .N(T5 + LM - T2)) u_u0_d (
      .clock(clock), .advance(advance), .din(u0_ff), .dout(u0_d)
   );
   tcs_delay #(.W(64), .N(T6 - T5)) u_bb_o (
      .clock(clock), .advance(advance), .din(bb_ff), .dout(bb_out)
   );
   tcs_delay #(.W(1), .N(T6 - T3)) u_err3_d (
      .clock(clock), .advance(advance), .din(err3), .dout(err_out)
   );

   tcs_mul u_m3 (.clock(clock), .advance(advance), .a(bb_ff), .b(l0_d), .p(m3));
   tcs_mul u_m4 (.clock(clock), .advance(advance), .a(cc_m4), .b(l30_d), .p(m4));

   always_ff @(posedge clock) begin
      if (advance) begin
         aa1_ff <= tcs_pkg::sat_sub(u0_d, m3);
         m4_ff  <= m4;
         aa_ff  <= tcs_pkg::sat_sub(aa1_ff, m4_ff);
      end
   end

   // Output register: rescale and clear the coefficients on error.
   word_type rsp_a_ff, rsp_b_ff, rsp_c_ff;
   logic rsp_err_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_err_ff <= err_out;
         if (err_out) begin
            rsp_a_ff <= '0;
            rsp_b_ff <= '0;
            rsp_c_ff <= '0;
         end else begin
            rsp_a_ff <= scale_out(aa_ff);
            rsp_b_ff <= scale_out(bb_out);
            rsp_c_ff <= scale_out(cc_out);
         end
      end
   end

   assign rsp_tdata = {rsp_c_ff, rsp_b_ff, rsp_a_ff};
   assign rsp_tuser = rsp_err_ff;

   `TCS_ASSERT(a_stall_blocks_input, (rsp_tvalid && !rsp_tready) |-> !req_tready)
   `TCS_ASSERT(a_error_zero, (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0))
   `TCS_ASSERT(a_accept_enters, (req_tvalid && req_tready) |=> valid_ff[0])
   `TCS_ASSERT_ALWAYS(a_reset_clears, $past(reset) |-> !rsp_tvalid)
endmodule
`default_nettype wire

### design/tcs_delay.sv
// Enabled shift line that keeps a value aligned with the pipeline.
`default_nettype none
module tcs_delay #(
   parameter int W = 64,
   parameter int N = 1
) (
   input  wire logic         clock,
   input  wire logic         advance,
   input  wire logic [W-1:0] din,
   output logic      [W-1:0] dout
);
   logic [W-1:0] tap_ff [0:N-1];

   always_ff @(posedge clock) begin
      if (advance) begin
         tap_ff[0] <= din;
         for (int i = 1; i < N; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[N-1];
endmodule
`default_nettype wire

### design/tcs_mul.sv
// Pipelined fixed-point multiply: round(a*b / 2^SH), saturating.
`default_nettype none
module tcs_mul #(
   parameter int SH = tcs_pkg::WORK_FRAC
) (
   input  wire logic              clock,
   input  wire logic              advance,
   input  wire tcs_pkg::word_type a,
   input  wire tcs_pkg::word_type b,
   output tcs_pkg::word_type      p
);
   localparam logic [127:0] RB = 128'd1 << (SH - 1);

   logic [63:0]  ma_ff, mb_ff;
   logic         neg0_ff, neg1_ff, neg2_ff;
   logic [63:0]  ll_ff, lh_ff, hl_ff, hh_ff;
   logic [127:0] sum_ff;
   tcs_pkg::word_type p_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         ma_ff   <= tcs_pkg::mag64(a);
         mb_ff   <= tcs_pkg::mag64(b);
         neg0_ff <= a[63] ^ b[63];
         ll_ff   <= ma_ff[31:0]  * mb_ff[31:0];
         lh_ff   <= ma_ff[31:0]  * mb_ff[63:32];
         hl_ff   <= ma_ff[63:32] * mb_ff[31:0];
         hh_ff   <= ma_ff[63:32] * mb_ff[63:32];
         neg1_ff <= neg0_ff;
         sum_ff  <= (128'(hh_ff) << 64) + (128'(lh_ff) << 32) + (128'(hl_ff) << 32)
                    + 128'(ll_ff) + RB;
         neg2_ff <= neg1_ff;
         if (|sum_ff[127:64+SH]) begin
            p_ff <= tcs_pkg::make64(neg2_ff, '1);
         end else begin
            p_ff <= tcs_pkg::make64(neg2_ff, sum_ff[63+SH:SH]);
         end
      end
   end

   assign p = p_ff;
endmodule
`default_nettype wire

### design/tcs_div.sv
// Pipelined restoring divider: round(n * 2^SH / d), one quotient bit per stage.
`default_nettype none
module tcs_div #(
   parameter int SH = tcs_pkg::WORK_FRAC
) (
   input  wire logic              clock,
   input  wire logic              advance,
   input  wire tcs_pkg::word_type n,
   input  wire tcs_pkg::word_type d,
   output tcs_pkg::word_type      q
);
   localparam int STEPS = 64 + SH;

   logic [63:0] r_ff   [0:STEPS];
   logic [63:0] q_ff   [0:STEPS];
   logic [63:0] nm_ff  [0:STEPS];
   logic [63:0] dm_ff  [0:STEPS];
   logic        ovf_ff [0:STEPS];
   logic        neg_ff [0:STEPS];
   logic        dz_ff  [0:STEPS];
   logic [63:0] qr_ff;
   logic        ovf_r_ff, neg_r_ff, dz_r_ff;
   tcs_pkg::word_type q_out_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         nm_ff[0]  <= tcs_pkg::mag64(n);
         dm_ff[0]  <= tcs_pkg::mag64(d);
         neg_ff[0] <= n[63] ^ d[63];
         dz_ff[0]  <= (d == '0);
         r_ff[0]   <= '0;
         q_ff[0]   <= '0;
         ovf_ff[0] <= 1'b0;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic        bit_in;
      logic [63:0] rs;
      if (i < 64) begin : g_num
         assign bit_in = nm_ff[i][63-i];
      end else begin : g_zero
         assign bit_in = 1'b0;
      end
      // The remainder stays below the divisor, so bit 63 is always clear.
      assign rs = {r_ff[i][62:0], bit_in};

      always_ff @(posedge clock) begin
         if (advance) begin
            nm_ff[i+1]  <= nm_ff[i];
            dm_ff[i+1]  <= dm_ff[i];
            neg_ff[i+1] <= neg_ff[i];
            dz_ff[i+1]  <= dz_ff[i];
            ovf_ff[i+1] <= ovf_ff[i] | q_ff[i][63] | q_ff[i][62];
            if (rs >= dm_ff[i]) begin
               r_ff[i+1] <= rs - dm_ff[i];
               q_ff[i+1] <= {q_ff[i][62:0], 1'b1};
            end else begin
               r_ff[i+1] <= rs;
               q_ff[i+1] <= {q_ff[i][62:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         qr_ff    <= q_ff[STEPS] + 64'(r_ff[STEPS] >= (dm_ff[STEPS] - r_ff[STEPS]));
         ovf_r_ff <= ovf_ff[STEPS];
         neg_r_ff <= neg_ff[STEPS];
         dz_r_ff  <= dz_ff[STEPS];
         if (dz_r_ff) begin
            q_out_ff <= '0;
         end else if (ovf_r_ff) begin
            q_out_ff <= tcs_pkg::make64(neg_r_ff, '1);
         end else begin
            q_out_ff <= tcs_pkg::make64(neg_r_ff, qr_ff);
         end
      end
   end

   assign q = q_out_ff;
endmodule
`default_nettype wire

### design/tcs_ln.sv
// Pipelined natural log of a resistance: log2 by repeated squaring, then times ln 2.
`default_nettype none
module tcs_ln (
   input  wire logic                       clock,
   input  wire logic                       advance,
   input  wire logic [tcs_pkg::RLN_W-1:0]  r,
   output tcs_pkg::word_type               ln_out
);
   localparam int NF = tcs_pkg::WORK_FRAC;

   logic [4:0]    k_sel;
   logic [4:0]    k_ff    [0:NF];
   logic [63:0]   y_ff    [0:NF];
   logic [NF-1:0] frac_ff [0:NF];
   tcs_pkg::word_type log2_val;

   always_comb begin
      k_sel = '0;
      for (int i = 0; i < tcs_pkg::RLN_W; i++) begin
         if (r[i]) begin
            k_sel = 5'(i);
         end
      end
   end

   // Normalize so the mantissa sits in [1,2) with 62 fraction bits.
   always_ff @(posedge clock) begin
      if (advance) begin
         k_ff[0]    <= k_sel;
         y_ff[0]    <= 64'(r) << (6'd62 - 6'(k_sel));
         frac_ff[0] <= '0;
      end
   end

   for (genvar s = 0; s < NF; s++) begin : g_sq
      logic [63:0]   ll_ff;
      logic [62:0]   lh_ff;
      logic [61:0]   hh_ff;
      logic [4:0]    ka_ff;
      logic [NF-1:0] fa_ff;
      logic [127:0]  prod;
      logic [63:0]   ny;

      assign prod = (128'(hh_ff) << 64) + (128'(lh_ff) << 33) + 128'(ll_ff);
      assign ny   = prod[125:62];

      always_ff @(posedge clock) begin
         if (advance) begin
            ll_ff <= y_ff[s][31:0]  * y_ff[s][31:0];
            lh_ff <= y_ff[s][31:0]  * y_ff[s][62:32];
            hh_ff <= y_ff[s][62:32] * y_ff[s][62:32];
            ka_ff <= k_ff[s];
            fa_ff <= frac_ff[s];
            k_ff[s+1]    <= ka_ff;
            frac_ff[s+1] <= {fa_ff[NF-2:0], ny[63]};
            y_ff[s+1]    <= ny[63] ? (ny >> 1) : ny;
         end
      end
   end

   assign log2_val = tcs_pkg::word_type'({11'd0, k_ff[NF], frac_ff[NF]});

   tcs_mul #(.SH(62)) u_ln2 (
      .clock  (clock),
      .advance(advance),
      .a      (log2_val),
      .b      (tcs_pkg::LN2_Q62),
      .p      (ln_out)
   );
endmodule
`default_nettype wire
